/* rtl/fct_pkg.sv */
// Shared constants, types and control structs of the frustum cull tester.
// Used by fct_mac, frustum_cull_tester and the bench; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package fct_pkg;

    // plane store
    localparam int PLANE_COUNT = 6;
    localparam int PLANE_W     = (PLANE_COUNT > 1) ? $clog2(PLANE_COUNT) : 1;

    // field widths
    localparam int COORD_W = 32;    // signed Q16.16 coordinate
    localparam int H_W     = 31;    // unsigned Q15.16 radius or height
    localparam int FRAC_W  = 16;

    // stream widths
    localparam int IN_DATA_W  = 320;
    localparam int IN_USER_W  = 6;
    localparam int OUT_DATA_W = 8;
    localparam int H_LSB      = 9 * COORD_W;

    // shared multiply-accumulate datapath
    localparam int OP_W   = COORD_W + 1;    // 33-bit signed operands
    localparam int PROD_W = 2 * OP_W;       // full signed product
    localparam int SVAL_W = 2 * COORD_W;    // height-scaled offset
    localparam int ACC_W  = 100;            // holds a Q48.48 dot product

    // item kinds carried in tuser
    typedef enum logic [2:0] {
        K_LOAD   = 3'd0,
        K_POINT  = 3'd1,
        K_SPHERE = 3'd2,
        K_TRI    = 3'd3,
        K_VOL    = 3'd4
    } t_kind;

    // classification result
    typedef enum logic [1:0] {
        V_CONTAINS  = 2'd0,
        V_INTERSECT = 2'd1,
        V_OUTSIDE   = 2'd2
    } t_verdict;

    // what the accumulate step does with the product
    typedef enum logic [1:0] {
        M_DIRECT = 2'd0,    // acc += (v - a) * n
        M_SCALE  = 2'd1,    // sval = v * h - (a << 16)
        M_LO     = 2'd2,    // acc += sval[31:0] * n
        M_HI     = 2'd3     // acc += (sval[63:32] * n) << 32
    } t_mac_mode;

    typedef struct packed {
        logic      clr;
        logic      mul_en;
        logic      acc_en;
        t_mac_mode mode;
    } t_mac_ctrl;

endpackage

`default_nettype wire

/* rtl/fct_mac.sv */
// Shared multiply-accumulate unit of the frustum cull tester: one 33x33
// signed multiplier, a product register, the wide accumulator and the
// scaled-offset register. Depends on fct_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fct_mac (
    input  logic                             i_clk,
    input  fct_pkg::t_mac_ctrl               i_ctrl,
    input  logic signed [fct_pkg::OP_W-1:0]  i_op_a,
    input  logic signed [fct_pkg::OP_W-1:0]  i_op_b,
    input  logic signed [fct_pkg::COORD_W-1:0] i_anchor,
    output logic signed [fct_pkg::ACC_W-1:0] o_acc,
    output logic        [fct_pkg::SVAL_W-1:0] o_sval
);
    import fct_pkg::*;

    logic signed [PROD_W-1:0] r_prod;
    logic signed [ACC_W-1:0]  r_acc;
    logic        [SVAL_W-1:0] r_sval;
    logic signed [ACC_W-1:0]  w_addend;
    logic        [SVAL_W-1:0] w_anchor_q;

    // product aligned for the accumulator; high half of sval is weighted 2^32
    always_comb begin
        if (i_ctrl.mode == M_HI) begin
            w_addend = {{(ACC_W-PROD_W-COORD_W){r_prod[PROD_W-1]}}, r_prod,
                        {COORD_W{1'b0}}};
        end else begin
            w_addend = {{(ACC_W-PROD_W){r_prod[PROD_W-1]}}, r_prod};
        end
        // anchor taken as Q32.32
        w_anchor_q = {{(SVAL_W-COORD_W-FRAC_W){i_anchor[COORD_W-1]}}, i_anchor,
                      {FRAC_W{1'b0}}};
    end

    // multiply stage
    always_ff @(posedge i_clk) begin
        if (i_ctrl.mul_en) begin
            r_prod <= i_op_a * i_op_b;
        end
    end

    // accumulate or form the scaled offset
    always_ff @(posedge i_clk) begin
        if (i_ctrl.clr) begin
            r_acc <= '0;
        end else if (i_ctrl.acc_en && i_ctrl.mode != M_SCALE) begin
            r_acc <= r_acc + w_addend;
        end
        if (i_ctrl.acc_en && i_ctrl.mode == M_SCALE) begin
            r_sval <= r_prod[SVAL_W-1:0] - w_anchor_q;
        end
    end

    assign o_acc  = r_acc;
    assign o_sval = r_sval;

endmodule

`default_nettype wire

/* rtl/frustum_cull_tester.sv */
// Frustum cull tester top level: plane store, item registers, sequencer
// and output register. Depends on fct_pkg and fct_mac.
//
// Usage:
//   Input words arrive on s_axis; tuser carries the kind and plane slot,
//   tdata the three vertices and the radius or height. A load word writes
//   one plane in its accept cycle and gives no result; kinds 5 to 7 are
//   dropped. A test word classifies a point, sphere, triangle or triangle
//   volume against all planes and returns one verdict word on m_axis.
//   Every product passes the operand, multiply and accumulate states on
//   the one shared multiplier; each vertex distance is 3 products plus a
//   judge state, and each plane ends with a plane state. Scaled products
//   of the triangle volume use three multiplies each. After the last
//   plane the sequencer waits in a done state for the output register.
//   s_axis_tready is high only while the sequencer is idle.
//   Reset clears all planes to zero and empties the output register.
//   A stalled result waits in the output register; the next word is
//   accepted meanwhile, and a finished verdict waits until the register
//   frees up.
`timescale 1ns / 1ps
`default_nettype none

module frustum_cull_tester (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // slave side
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // tdata, low bit up: first_x, first_y, first_z, second_x, second_y,
    // second_z, third_x, third_y, third_z (32 each), radius_or_height (31)
    input  logic [fct_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    // tuser, low bit up: kind (3), plane_slot (3)
    input  logic [fct_pkg::IN_USER_W-1:0]     s_axis_tuser,
    // master side
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // tdata, low bit up: verdict (2)
    output logic [fct_pkg::OUT_DATA_W-1:0]    m_axis_tdata
);
    import fct_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_OPND  = 7'b0000010,
        S_MULT  = 7'b0000100,
        S_ACCUM = 7'b0001000,
        S_JUDGE = 7'b0010000,
        S_PLANE = 7'b0100000,
        S_DONE  = 7'b1000000
    } t_state;

    t_state                   r_state, n_state;
    t_kind                    r_kind;
    logic [H_W-1:0]           r_h;
    logic signed [COORD_W-1:0] r_v [3][3];
    logic [PLANE_W-1:0]       r_plane;
    logic [1:0]               r_vtx;
    logic [1:0]               r_comp;
    logic [1:0]               r_part;
    logic                     r_scaled;
    logic [1:0]               r_hits;
    logic [1:0]               r_shits;
    logic                     r_sph_out;
    t_verdict                 r_verdict;
    logic signed [OP_W-1:0]   r_op_a, r_op_b;
    logic                     r_out_valid;
    t_verdict                 r_out_verdict;

    // plane store
    logic signed [COORD_W-1:0] r_norm [PLANE_COUNT][3];
    logic signed [COORD_W-1:0] r_anch [PLANE_COUNT][3];

    logic signed [COORD_W-1:0] w_in [3][3];
    t_kind                    w_in_kind;
    logic [2:0]               w_in_slot;
    logic                     w_accept;
    logic                     w_start;
    logic                     w_load;

    logic signed [COORD_W-1:0] w_vc, w_nc, w_ac;
    t_mac_mode                w_mode;
    t_mac_ctrl                w_ctrl;
    logic signed [ACC_W-1:0]  w_acc;
    logic [SVAL_W-1:0]        w_sval;
    logic signed [ACC_W-1:0]  w_sph_sum;
    logic                     w_neg;
    logic [1:0]               w_hits_nx;
    logic                     w_last_vtx;
    logic                     w_last_part;
    t_verdict                 w_pv;
    logic                     w_out_free;

    // unpack the input word
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            for (int c = 0; c < 3; c++) begin
                w_in[k][c] = s_axis_tdata[(3*k+c)*COORD_W +: COORD_W];
            end
        end
        w_in_kind = t_kind'(s_axis_tuser[2:0]);
        w_in_slot = s_axis_tuser[5:3];
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_load        = w_accept && (w_in_kind == K_LOAD);
    assign w_start       = w_accept && (w_in_kind inside {K_POINT, K_SPHERE, K_TRI, K_VOL});

    // current operand picks
    always_comb begin
        w_vc = r_v[r_vtx][r_comp];
        w_nc = r_norm[r_plane][r_comp];
        w_ac = r_anch[r_plane][r_comp];
        if (!r_scaled) begin
            w_mode = M_DIRECT;
        end else begin
            case (r_part)
                2'd0:    w_mode = M_SCALE;
                2'd1:    w_mode = M_LO;
                default: w_mode = M_HI;
            endcase
        end
    end

    // shared unit control
    always_comb begin
        w_ctrl.clr    = w_start || (r_state == S_JUDGE);
        w_ctrl.mul_en = (r_state == S_MULT);
        w_ctrl.acc_en = (r_state == S_ACCUM);
        w_ctrl.mode   = w_mode;
    end

    fct_mac u_mac (
        .i_clk    (i_clk),
        .i_ctrl   (w_ctrl),
        .i_op_a   (r_op_a),
        .i_op_b   (r_op_b),
        .i_anchor (w_ac),
        .o_acc    (w_acc),
        .o_sval   (w_sval)
    );

    // distance sign checks
    always_comb begin
        w_neg       = w_acc[ACC_W-1];
        w_sph_sum   = w_acc + {{(ACC_W-H_W-FRAC_W){1'b0}}, r_h, {FRAC_W{1'b0}}};
        w_hits_nx   = r_hits + 2'(w_neg);
        w_last_vtx  = (r_kind == K_POINT || r_kind == K_SPHERE) ? (r_vtx == 2'd0)
                                                                : (r_vtx == 2'd2);
        w_last_part = !r_scaled || (r_part == 2'd2);
        w_out_free  = !r_out_valid || m_axis_tready;
    end

    // verdict of the current plane
    always_comb begin
        case (r_kind)
            K_POINT: begin
                w_pv = (r_hits != 2'd0) ? V_OUTSIDE : V_CONTAINS;
            end
            K_SPHERE: begin
                if (r_sph_out)            w_pv = V_OUTSIDE;
                else if (r_hits != 2'd0)  w_pv = V_INTERSECT;
                else                      w_pv = V_CONTAINS;
            end
            K_TRI: begin
                if (r_hits == 2'd3)       w_pv = V_OUTSIDE;
                else if (r_hits != 2'd0)  w_pv = V_INTERSECT;
                else                      w_pv = V_CONTAINS;
            end
            K_VOL: begin
                if (r_hits == 2'd3)       w_pv = (r_shits == 2'd3) ? V_OUTSIDE : V_INTERSECT;
                else if (r_hits != 2'd0)  w_pv = V_INTERSECT;
                else                      w_pv = V_CONTAINS;
            end
            default: begin
                w_pv = V_CONTAINS;
            end
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (w_start) n_state = S_OPND;
            S_OPND:  n_state = S_MULT;
            S_MULT:  n_state = S_ACCUM;
            S_ACCUM: n_state = (w_last_part && r_comp == 2'd2) ? S_JUDGE : S_OPND;
            S_JUDGE: begin
                if (!w_last_vtx ||
                    (!r_scaled && r_kind == K_VOL && w_hits_nx == 2'd3)) begin
                    n_state = S_OPND;
                end else begin
                    n_state = S_PLANE;
                end
            end
            S_PLANE: n_state = (32'(r_plane) == PLANE_COUNT - 1) ? S_DONE : S_OPND;
            S_DONE:  if (w_out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // plane store writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int p = 0; p < PLANE_COUNT; p++) begin
                for (int c = 0; c < 3; c++) begin
                    r_norm[p][c] <= '0;
                    r_anch[p][c] <= '0;
                end
            end
        end else if (w_load && (32'(w_in_slot) < PLANE_COUNT)) begin
            for (int c = 0; c < 3; c++) begin
                r_norm[PLANE_W'(w_in_slot)][c] <= w_in[0][c];
                r_anch[PLANE_W'(w_in_slot)][c] <= w_in[1][c];
            end
        end
    end

    // item registers, captured on a test word
    always_ff @(posedge i_clk) begin
        if (w_start) begin
            for (int k = 0; k < 3; k++) begin
                for (int c = 0; c < 3; c++) begin
                    r_v[k][c] <= w_in[k][c];
                end
            end
            r_h <= s_axis_tdata[H_LSB +: H_W];
        end
    end

    // operand registers for the shared multiplier
    always_ff @(posedge i_clk) begin
        if (r_state == S_OPND) begin
            case (w_mode)
                M_DIRECT: begin
                    r_op_a <= {w_vc[COORD_W-1], w_vc} - {w_ac[COORD_W-1], w_ac};
                    r_op_b <= {w_nc[COORD_W-1], w_nc};
                end
                M_SCALE: begin
                    r_op_a <= {w_vc[COORD_W-1], w_vc};
                    r_op_b <= {{(OP_W-H_W){1'b0}}, r_h};
                end
                M_LO: begin
                    r_op_a <= {1'b0, w_sval[COORD_W-1:0]};
                    r_op_b <= {w_nc[COORD_W-1], w_nc};
                end
                default: begin
                    r_op_a <= {w_sval[SVAL_W-1], w_sval[SVAL_W-1:COORD_W]};
                    r_op_b <= {w_nc[COORD_W-1], w_nc};
                end
            endcase
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_kind    <= K_LOAD;
            r_plane   <= '0;
            r_vtx     <= '0;
            r_comp    <= '0;
            r_part    <= '0;
            r_scaled  <= 1'b0;
            r_hits    <= '0;
            r_shits   <= '0;
            r_sph_out <= 1'b0;
            r_verdict <= V_CONTAINS;
        end else begin
            r_state <= n_state;
            case (r_state)
                S_IDLE: begin
                    if (w_start) begin
                        r_kind    <= w_in_kind;
                        r_plane   <= '0;
                        r_vtx     <= '0;
                        r_comp    <= '0;
                        r_part    <= '0;
                        r_scaled  <= 1'b0;
                        r_hits    <= '0;
                        r_shits   <= '0;
                        r_sph_out <= 1'b0;
                        r_verdict <= V_CONTAINS;
                    end
                end
                S_ACCUM: begin
                    if (w_last_part) begin
                        r_part <= '0;
                        r_comp <= (r_comp == 2'd2) ? 2'd0 : r_comp + 2'd1;
                    end else begin
                        r_part <= r_part + 2'd1;
                    end
                end
                S_JUDGE: begin
                    if (r_scaled) begin
                        r_shits <= r_shits + 2'(w_neg);
                    end else begin
                        r_hits <= w_hits_nx;
                    end
                    if (r_kind == K_SPHERE && w_sph_sum[ACC_W-1]) begin
                        r_sph_out <= 1'b1;
                    end
                    if (!w_last_vtx) begin
                        r_vtx <= r_vtx + 2'd1;
                    end else if (!r_scaled && r_kind == K_VOL && w_hits_nx == 2'd3) begin
                        r_scaled <= 1'b1;
                        r_vtx    <= '0;
                    end
                end
                S_PLANE: begin
                    if (w_pv > r_verdict) begin
                        r_verdict <= w_pv;
                    end
                    r_hits    <= '0;
                    r_shits   <= '0;
                    r_sph_out <= 1'b0;
                    r_scaled  <= 1'b0;
                    r_vtx     <= '0;
                    if (32'(r_plane) != PLANE_COUNT - 1) begin
                        r_plane <= r_plane + 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_DONE && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && w_out_free) begin
            r_out_verdict <= r_verdict;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(OUT_DATA_W-2){1'b0}}, r_out_verdict};

    // scaled pass only follows three failing vertices of one plane
    a_scaled_after_reject: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_JUDGE && r_scaled) |-> (r_hits == 2'd3))
        else $error("scaled pass without full reject");

    // scaled pass only for the triangle volume test
    a_scaled_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_scaled |-> (r_kind == K_VOL))
        else $error("scaled pass on wrong kind");

    // sub-steps of a component exist only in the scaled pass
    a_part_scaled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_part != 2'd0) |-> r_scaled)
        else $error("product sub-step outside scaled pass");

    // single-vertex kinds never step the vertex counter
    a_single_vertex: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_kind == K_POINT || r_kind == K_SPHERE) && r_state != S_IDLE)
        |-> (r_vtx == 2'd0))
        else $error("vertex step on point or sphere");

    // a finished verdict with room goes out next cycle
    a_done_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && w_out_free) |=> (m_axis_tvalid && r_state == S_IDLE))
        else $error("verdict not delivered");

endmodule

`default_nettype wire

/* bench/frustum_cull_tester_tb.sv */
// Self-checking bench for frustum_cull_tester: loads plane sets, then streams
// point, sphere, triangle and triangle volume tests and checks each verdict.
// Depends on fct_pkg and the frustum_cull_tester RTL.
`timescale 1ns / 1ps

module frustum_cull_tester_tb;

    import fct_pkg::*;

    localparam int ONE             = 1 << FRAC_W;     // 1.0 in Q16.16
    localparam int HALF_BOX        = 10 * ONE;
    localparam int CMAX            = 32'sh7FFF_FFFF;
    localparam int CMIN            = 32'sh8000_0000;
    localparam int ITEM_COUNT      = 750;
    localparam int PRESSURE_AFTER  = 40;               // verdicts before the long hold-off
    localparam int PRESSURE_CYCLES = 1500;
    localparam int TAIL_CYCLES     = 800;              // longer than the worst-case test
    localparam int WATCHDOG_LIMIT  = 10000;

    // kinds the block drops without a verdict
    localparam logic [2:0] KIND_SPARE_LO = 3'd5;
    localparam logic [2:0] KIND_SPARE_HI = 3'd7;

    typedef logic signed [127:0] t_exact;

    // one input word, field by field
    typedef struct packed {
        logic [2:0]        slot;
        logic [2:0]        kind;
        logic [H_W-1:0]    h;
        logic [8:0][31:0]  c;     // first xyz, second xyz, third xyz
    } t_cull_word;

    //------------------------------------------------------------------
    // Plane store copy, verdict predictor and check of returned verdicts
    //------------------------------------------------------------------
    class cull_scoreboard;
        logic signed [COORD_W-1:0] normal_x [PLANE_COUNT];
        logic signed [COORD_W-1:0] normal_y [PLANE_COUNT];
        logic signed [COORD_W-1:0] normal_z [PLANE_COUNT];
        logic signed [COORD_W-1:0] anchor_x [PLANE_COUNT];
        logic signed [COORD_W-1:0] anchor_y [PLANE_COUNT];
        logic signed [COORD_W-1:0] anchor_z [PLANE_COUNT];
        t_verdict pending_verdicts [$];
        int mismatches;
        int plane_loads;
        int dropped_words;
        int verdicts_seen;
        int verdict_mix [3];

        function new();
            foreach (normal_x[p]) begin
                normal_x[p] = '0;
                normal_y[p] = '0;
                normal_z[p] = '0;
                anchor_x[p] = '0;
                anchor_y[p] = '0;
                anchor_z[p] = '0;
            end
            foreach (verdict_mix[i]) verdict_mix[i] = 0;
        endfunction

        // exact Q32.32 signed distance of a vertex from plane p
        function t_exact vertex_dist(int p, t_exact x, t_exact y, t_exact z);
            return (x - anchor_x[p]) * normal_x[p] + (y - anchor_y[p]) * normal_y[p]
                 + (z - anchor_z[p]) * normal_z[p];
        endfunction

        // exact Q48.48 distance of a height-scaled vertex; anchor moved to Q32.32
        function t_exact scaled_dist(int p, t_exact x, t_exact y, t_exact z, t_exact hgt);
            t_exact ax, ay, az;
            ax = anchor_x[p];
            ay = anchor_y[p];
            az = anchor_z[p];
            return (x * hgt - (ax <<< FRAC_W)) * normal_x[p]
                 + (y * hgt - (ay <<< FRAC_W)) * normal_y[p]
                 + (z * hgt - (az <<< FRAC_W)) * normal_z[p];
        endfunction

        function t_verdict classify(t_cull_word w);
            t_exact vx [3];
            t_exact vy [3];
            t_exact vz [3];
            t_exact hgt, d;
            int fails, scaled_fails;
            t_verdict verdict;
            verdict = V_CONTAINS;
            hgt = {97'd0, w.h};
            for (int k = 0; k < 3; k++) begin
                vx[k] = $signed(w.c[3 * k]);
                vy[k] = $signed(w.c[3 * k + 1]);
                vz[k] = $signed(w.c[3 * k + 2]);
            end
            for (int p = 0; p < PLANE_COUNT; p++) begin
                if (w.kind == K_POINT) begin
                    if (vertex_dist(p, vx[0], vy[0], vz[0]) < 0) verdict = V_OUTSIDE;
                end else if (w.kind == K_SPHERE) begin
                    d = vertex_dist(p, vx[0], vy[0], vz[0]);
                    if (d + (hgt <<< FRAC_W) < 0) verdict = V_OUTSIDE;
                    else if (d < 0 && verdict == V_CONTAINS) verdict = V_INTERSECT;
                end else begin
                    fails = 0;
                    for (int k = 0; k < 3; k++)
                        if (vertex_dist(p, vx[k], vy[k], vz[k]) < 0) fails++;
                    if (fails == 3 && w.kind == K_VOL) begin
                        // whole triangle behind the plane: the scaled copy gets a say
                        scaled_fails = 0;
                        for (int k = 0; k < 3; k++)
                            if (scaled_dist(p, vx[k], vy[k], vz[k], hgt) < 0) scaled_fails++;
                        if (scaled_fails == 3) verdict = V_OUTSIDE;
                        else if (verdict == V_CONTAINS) verdict = V_INTERSECT;
                    end else if (fails == 3) begin
                        verdict = V_OUTSIDE;
                    end else if (fails > 0 && verdict == V_CONTAINS) begin
                        verdict = V_INTERSECT;
                    end
                end
            end
            return verdict;
        endfunction

        // accepted input word: update planes or queue the verdict it must give
        function void note_word(t_cull_word w);
            t_verdict v;
            if (w.kind == K_LOAD) begin
                if (w.slot < PLANE_COUNT) begin
                    normal_x[w.slot] = w.c[0];
                    normal_y[w.slot] = w.c[1];
                    normal_z[w.slot] = w.c[2];
                    anchor_x[w.slot] = w.c[3];
                    anchor_y[w.slot] = w.c[4];
                    anchor_z[w.slot] = w.c[5];
                    plane_loads++;
                end else begin
                    dropped_words++;
                end
            end else if (w.kind > K_VOL) begin
                dropped_words++;
            end else begin
                v = classify(w);
                verdict_mix[int'(v)]++;
                pending_verdicts = {pending_verdicts, v};
            end
        endfunction

        // accepted output word against the oldest queued verdict
        function void check_verdict(logic [1:0] got);
            t_verdict wanted;
            verdicts_seen++;
            if (pending_verdicts.size() == 0) begin
                mismatches++;
                $display("%0t: verdict %0d arrived with none expected", $time, got);
            end else begin
                wanted = pending_verdicts.pop_front();
                if (got !== wanted) begin
                    mismatches++;
                    $display("%0t: verdict mismatch, expected %0d (%s) actual %0d",
                             $time, wanted, wanted.name(), got);
                end
            end
        endfunction
    endclass

    //------------------------------------------------------------------
    // Signals, clock, block
    //------------------------------------------------------------------
    logic                  i_clk;
    logic                  i_rst_n       = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
    logic [IN_USER_W-1:0]  s_axis_tuser  = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;

    cull_scoreboard sb = new();
    int send_calm = 0;
    int sink_calm = 0;
    int idle_cycles = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    frustum_cull_tester dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    //------------------------------------------------------------------
    // Random helpers
    //------------------------------------------------------------------

    // idle gap: mostly none or short, a few long, with calm stretches of none
    function automatic int pick_gap(ref int calm);
        int r;
        if (calm > 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 49) == 0) calm = $urandom_range(20, 60);
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(30, 80);
    endfunction

    function automatic int rand_span(int s);
        return (s == 0) ? 0 : int'($urandom_range(0, 2 * s)) - s;
    endfunction

    // mostly scene-sized values, some mid-range, some anywhere in 32 bits
    function automatic int rand_coord();
        int r;
        r = $urandom_range(0, 99);
        if (r < 82) return rand_span(48 * ONE);
        if (r < 94) return $signed($urandom) >>> $urandom_range(4, 20);
        return $urandom;
    endfunction

    function automatic t_cull_word rand_raw();
        t_cull_word w;
        for (int j = 0; j < 9; j++) w.c[j] = $urandom;
        w.h    = H_W'($urandom_range(0, CMAX));
        w.kind = 3'($urandom_range(0, 7));
        w.slot = 3'($urandom_range(0, 7));
        return w;
    endfunction

    function automatic t_cull_word mk_word(logic [2:0] kind, logic [2:0] slot,
                                           int ax, int ay, int az, int bx, int by, int bz,
                                           int cx, int cy, int cz, int hgt);
        t_cull_word w;
        w.kind = kind;
        w.slot = slot;
        w.c    = {cz, cy, cx, bz, by, bx, az, ay, ax};
        w.h    = hgt[H_W-1:0];
        return w;
    endfunction

    // one wall of an axis-aligned box, normal pointing inward, with optional skew
    function automatic t_cull_word box_plane(int slot, int half, int jitter);
        t_cull_word w;
        int axis;
        w      = rand_raw();
        axis   = slot / 2;
        w.kind = K_LOAD;
        w.slot = 3'(slot);
        for (int j = 0; j < 3; j++) begin
            w.c[j]     = (j == axis) ? ((slot % 2) ? -ONE : ONE) : rand_span(jitter);
            w.c[3 + j] = (j == axis) ? ((slot % 2) ? half : -half) : rand_span(jitter);
        end
        return w;
    endfunction

    function automatic t_cull_word rand_test();
        t_cull_word w;
        int r;
        w = rand_raw();
        r = $urandom_range(0, 99);
        w.kind = (r < 20) ? K_POINT : (r < 45) ? K_SPHERE : (r < 70) ? K_TRI : K_VOL;
        for (int j = 0; j < 3; j++) w.c[j] = rand_coord();
        // triangles mostly small, so they straddle walls or sit behind one
        for (int j = 3; j < 9; j++)
            w.c[j] = ($urandom_range(0, 9) < 7) ? w.c[j % 3] + rand_span(8 * ONE)
                                                 : rand_coord();
        r = $urandom_range(0, 99);
        if (w.kind == K_SPHERE && r < 85) w.h = H_W'($urandom_range(0, 16 * ONE));
        if (w.kind == K_VOL && r < 85) w.h = H_W'($urandom_range(ONE / 8, 3 * ONE));
        return w;
    endfunction

    //------------------------------------------------------------------
    // Driving tasks
    //------------------------------------------------------------------
    task automatic send_word(input t_cull_word w);
        int gap;
        gap = pick_gap(send_calm);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {1'b0, w.h, w.c};
        s_axis_tuser  <= {w.slot, w.kind};
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic load_frustum();
        t_cull_word w;
        int r;
        for (int s = 0; s < PLANE_COUNT; s++) begin
            w = box_plane(s, $urandom_range(2, 40) * ONE, $urandom_range(0, ONE / 4));
            // now and then a blank or wild plane
            r = $urandom_range(0, 19);
            if (r == 0) w.c = '0;
            if (r == 1) for (int j = 0; j < 6; j++) w.c[j] = $urandom;
            send_word(w);
        end
    endtask

    task automatic run_directed();
        // all planes zero after reset: nothing is rejected
        send_word(mk_word(K_POINT, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_word(mk_word(K_SPHERE, 7, CMAX, CMIN, CMAX, CMIN, CMAX, CMIN,
                          CMAX, CMIN, CMAX, CMAX));
        for (int s = 0; s < PLANE_COUNT; s++) send_word(box_plane(s, HALF_BOX, 0));
        // loads past the last slot and spare kinds must leave the planes alone
        send_word(mk_word(K_LOAD, 6, CMIN, CMIN, CMIN, CMAX, CMAX, CMAX, 0, 0, 0, 0));
        send_word(mk_word(K_LOAD, 7, CMAX, CMAX, CMAX, CMIN, CMIN, CMIN, 0, 0, 0, 0));
        send_word(mk_word(KIND_SPARE_LO, 0, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN,
                          CMIN, CMIN, CMIN, CMAX));
        send_word(mk_word(KIND_SPARE_HI, 7, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX,
                          CMAX, CMAX, CMAX, CMAX));
        // points in and out of the box
        send_word(mk_word(K_POINT, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_word(mk_word(K_POINT, 3, 20 * ONE, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        // sphere center just past a wall, then clear of it
        send_word(mk_word(K_SPHERE, 0, HALF_BOX + ONE / 2, 0, 0, 0, 0, 0, 0, 0, 0, ONE));
        send_word(mk_word(K_SPHERE, 0, 12 * ONE, 0, 0, 0, 0, 0, 0, 0, 0, ONE));
        // triangles: inside, straddling, behind one wall
        send_word(mk_word(K_TRI, 0, ONE, ONE, ONE, 2 * ONE, -3 * ONE, 0,
                          -4 * ONE, 0, 5 * ONE, 0));
        send_word(mk_word(K_TRI, 0, 9 * ONE, 0, 0, 11 * ONE, 0, 0, 0, 0, 0, 0));
        send_word(mk_word(K_TRI, 0, 11 * ONE, 0, 0, 12 * ONE, ONE, 0,
                          13 * ONE, -ONE, 2 * ONE, 0));
        // volume: half height pulls it back in, unit height does not
        send_word(mk_word(K_VOL, 0, 12 * ONE, 0, 0, 13 * ONE, 0, 0, 14 * ONE, 0, 0, ONE / 2));
        send_word(mk_word(K_VOL, 0, 12 * ONE, 0, 0, 13 * ONE, 0, 0, 14 * ONE, 0, 0, ONE));
        // field extremes
        send_word(mk_word(K_POINT, 0, CMAX, CMAX, CMAX, 0, 0, 0, 0, 0, 0, 0));
        send_word(mk_word(K_TRI, 0, CMIN, CMIN, CMIN, CMAX, CMAX, CMAX,
                          CMIN, CMAX, CMIN, CMAX));
        send_word(mk_word(K_LOAD, 0, CMIN, CMAX, CMIN, CMAX, CMIN, CMAX, 0, 0, 0, 0));
        send_word(mk_word(K_VOL, 0, CMIN, CMAX, CMIN, CMAX, CMIN, CMAX,
                          CMIN, CMIN, CMIN, CMAX));
        send_word(mk_word(K_SPHERE, 0, CMAX, CMIN, CMAX, 0, 0, 0, 0, 0, 0, CMAX));
    endtask

    task automatic run_random();
        t_cull_word w;
        int counted, until_reload, r;
        counted      = 0;
        until_reload = 0;
        while (counted < ITEM_COUNT) begin
            r = $urandom_range(0, 99);
            if (until_reload == 0) begin
                load_frustum();
                counted += PLANE_COUNT;
                until_reload = $urandom_range(30, 90);
            end else if (r < 3) begin
                // stray single-plane load, slot possibly out of range
                w = rand_raw();
                w.kind = K_LOAD;
                send_word(w);
                if (w.slot < PLANE_COUNT) counted++;
            end else if (r < 5) begin
                w = rand_raw();
                w.kind = 3'($urandom_range(KIND_SPARE_LO, KIND_SPARE_HI));
                send_word(w);
            end else begin
                send_word(rand_test());
                counted++;
                until_reload--;
            end
        end
    endtask

    //------------------------------------------------------------------
    // Stimulus and end of run
    //------------------------------------------------------------------
    initial begin : stimulus
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        run_directed();
        run_random();
        s_axis_tvalid <= 1'b0;
        while (sb.pending_verdicts.size() != 0) @(posedge i_clk);
        // let any late or stray verdict show up
        repeat (TAIL_CYCLES) @(posedge i_clk);
        $display("run covered %0d plane loads, %0d dropped words, %0d verdicts checked",
                 sb.plane_loads, sb.dropped_words, sb.verdicts_seen);
        $display("verdicts: contains %0d, intersects %0d, outside %0d; %0d bad",
                 sb.verdict_mix[0], sb.verdict_mix[1], sb.verdict_mix[2], sb.mismatches);
        if (sb.mismatches == 0 && sb.pending_verdicts.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // result side: random back-pressure plus one long hold-off
    initial begin : result_sink
        int gap;
        bit pressure_done;
        pressure_done = 1'b0;
        wait (i_rst_n);
        @(posedge i_clk);
        forever begin
            if (!pressure_done && sb.verdicts_seen >= PRESSURE_AFTER) begin
                pressure_done = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (PRESSURE_CYCLES) @(posedge i_clk);
            end
            gap = pick_gap(sink_calm);
            if (gap > 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge i_clk);
        end
    end

    // handshake monitor, sampled at the clock edge
    always @(posedge i_clk) begin : word_monitor
        t_cull_word w;
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            w.c    = s_axis_tdata[H_LSB-1:0];
            w.h    = s_axis_tdata[H_LSB +: H_W];
            w.kind = s_axis_tuser[2:0];
            w.slot = s_axis_tuser[5:3];
            sb.note_word(w);
        end
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_verdict(m_axis_tdata[1:0]);
    end

    // watchdog: too long without any word moving on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: no word moved for %0d cycles", $time, WATCHDOG_LIMIT);
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

endmodule

/* files.f */
rtl/fct_pkg.sv
rtl/fct_mac.sv
rtl/frustum_cull_tester.sv
bench/frustum_cull_tester_tb.sv
